### hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for hashed drive steering with byte credits.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // FNV-1a 64-bit constants
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  // FNV prime 2^40 + 0x1B3, taken apart into shift-add terms
  localparam int unsigned FNV_TERMS = 7;
  localparam int unsigned FNV_SHIFT [FNV_TERMS] = '{40, 8, 7, 5, 4, 1, 0};

  // Field widths
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned CREDIT_W = 21;
  localparam int unsigned NEED_W   = CREDIT_W + 1;
  localparam int unsigned COUNT_W  = 5;

  // Number of drive credit entries
  localparam int unsigned MAX_DRIVES = 16;

  // Block rounding
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // Remainder unit: bits retired per cycle
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0]  COUNT_RESET = 5'd4;
  localparam logic [CREDIT_W-1:0] CAP_RESET   = 21'd262144;

  // Register indexes
  localparam logic REG_DRIVE_COUNT    = 1'b0;
  localparam logic REG_DRIVE_CAPACITY = 1'b1;

  // Command codes
  localparam logic CMD_KEY    = 1'b0;
  localparam logic CMD_RETURN = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_OUT
  } hsc_state_e;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } hsc_stat_t;

endpackage

### hdl/hsc_ram.sv
// ----------------------------------------------------------------------------
// hsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsc_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/hsc_fnv_mul.sv
// ----------------------------------------------------------------------------
// hsc_fnv_mul
// Multiply by the FNV prime modulo 2^64, one shift-add term per cycle.
// ----------------------------------------------------------------------------
module hsc_fnv_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       operand_i,
  output logic [63:0]       product_o,
  output hsc_pkg::hsc_stat_t stat_o
);

  localparam int unsigned CW = $clog2(hsc_pkg::FNV_TERMS);
  localparam logic [CW-1:0] LAST_TERM = CW'(hsc_pkg::FNV_TERMS - 1);

  logic [63:0]   x_q;
  logic [63:0]   acc_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // Control: run through the terms, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_TERM) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulate one shifted copy of the operand per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= operand_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (x_q << hsc_pkg::FNV_SHIFT[cnt_q]);
    end
  end

  assign product_o   = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hdl/hsc_mod.sv
// ----------------------------------------------------------------------------
// hsc_mod
// Remainder of a 64-bit word by a 5-bit divisor, a few bits per cycle.
// ----------------------------------------------------------------------------
module hsc_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hsc_pkg::HASH_W-1:0]   dividend_i,
  input  logic [hsc_pkg::COUNT_W-1:0]  divisor_i,
  output logic [hsc_pkg::COUNT_W-1:0]  rem_o,
  output hsc_pkg::hsc_stat_t           stat_o
);

  localparam int unsigned CW = $clog2(hsc_pkg::MOD_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(hsc_pkg::MOD_STEPS - 1);

  logic [hsc_pkg::HASH_W-1:0]  dvd_q;
  logic [hsc_pkg::COUNT_W-1:0] div_q;
  logic [hsc_pkg::COUNT_W-1:0] r_q;
  logic [hsc_pkg::COUNT_W-1:0] r_d;
  logic [CW-1:0]               cnt_q;
  logic                        busy_q;
  logic                        done_q;

  // Restoring remainder steps over the top dividend bits
  always_comb begin
    logic [hsc_pkg::COUNT_W:0] t;
    r_d = r_q;
    for (int i = 0; i < hsc_pkg::MOD_BITS; i++) begin
      t = {r_d, dvd_q[hsc_pkg::HASH_W-1-i]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r_d = t[hsc_pkg::COUNT_W-1:0];
    end
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out, hold the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << hsc_pkg::MOD_BITS;
      r_q   <= r_d;
    end
  end

  assign rem_o       = r_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hdl/hashed_drive_steering_with_credits.sv
// ----------------------------------------------------------------------------
// hashed_drive_steering_with_credits
// Hash request keys with FNV-1a, steer to a drive, gate by byte credit.
// ----------------------------------------------------------------------------
// Input words carry either one key byte (cmd 0) or a credit return (cmd 1).
// Key bytes fold into a 64-bit FNV-1a hash; the byte marked last yields one
// result word: drive = hash mod drive count, grant flag, charged bytes and
// the hash. Data requests are rounded up to whole blocks and charged against
// the chosen drive's credit; returns add back, saturating at the capacity.
// Both channels use valid/stall; the APB port writes drive_count (0x0) and
// drive_capacity (0x4), and a capacity write reloads every drive credit.
// One word is worked on at a time and in_stall_o is high meanwhile.
// A key byte passes through the seven-term shift-add multiply by the FNV
// prime. The last byte then goes through the 4-bit-per-cycle remainder unit,
// the credit RAM read and update (data requests only) and the load of the
// output register. A credit return goes through the RAM read and update.
// The result sits in an output register; while the receiver stalls it holds
// and further non-final words are still taken. Reset clears the hash to the
// offset basis, restores register defaults and marks all credits as full.
// ----------------------------------------------------------------------------
module hashed_drive_steering_with_credits (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic        is_data_op_i,
  input  logic [20:0] request_bytes_i,
  input  logic [3:0]  drive_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  drive_o,
  output logic        granted_o,
  output logic [20:0] charged_bytes_o,
  output logic [63:0] key_hash_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MAX_DRIVES = hsc_pkg::MAX_DRIVES;
  localparam int unsigned AW  = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
  localparam int unsigned CRW = hsc_pkg::CREDIT_W;
  localparam int unsigned NW  = hsc_pkg::NEED_W;
  localparam int unsigned BS  = hsc_pkg::BLOCK_SHIFT;
  localparam int unsigned CNW = hsc_pkg::COUNT_W;

  hsc_pkg::hsc_state_e state_q, state_d;

  // configuration and state
  logic [CNW-1:0]        count_q;
  logic [CRW-1:0]        cap_q;
  logic [63:0]           hash_q;
  logic [MAX_DRIVES-1:0] vld_q;

  // latched input word
  logic           cmd_q;
  logic           last_q;
  logic           data_q;
  logic [CRW-1:0] bytes_q;
  logic [AW-1:0]  addr_q;

  // result being built
  logic [63:0]    res_hash_q;
  logic [CNW-1:0] res_drive_q;
  logic           res_grant_q;
  logic [CRW-1:0] res_charge_q;

  // output register
  logic           out_valid_q;
  logic [3:0]     out_drive_q;
  logic           out_grant_q;
  logic [CRW-1:0] out_charge_q;
  logic [63:0]    out_hash_q;

  // unit hookup
  logic               mul_start;
  logic [63:0]        mul_product;
  hsc_pkg::hsc_stat_t mul_st;
  logic               mod_start;
  logic [CNW-1:0]     mod_rem;
  hsc_pkg::hsc_stat_t mod_st;
  logic               ram_we;
  logic [CRW-1:0]     ram_wdata;
  logic [CRW-1:0]     ram_rdata;

  // misc
  logic           in_acc;
  logic           out_free;
  logic           cfg_we;
  logic [CNW-1:0] eff_count;
  logic [NW-1:0]  round_sum;
  logic [NW-1:0]  need;
  logic [CRW-1:0] credit;
  logic [NW:0]    ret_sum;
  logic           fits;
  logic           idx_ok;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      hsc_pkg::REG_DRIVE_COUNT:    prdata = 32'(count_q);
      hsc_pkg::REG_DRIVE_CAPACITY: prdata = 32'(cap_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  hsc_fnv_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (hash_q ^ {56'd0, key_byte_i}),
    .product_o (mul_product),
    .stat_o    (mul_st)
  );

  hsc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mul_product),
    .divisor_i  (eff_count),
    .rem_o      (mod_rem),
    .stat_o     (mod_st)
  );

  hsc_ram #(
    .WIDTH (CRW),
    .DEPTH (MAX_DRIVES)
  ) u_credit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic on the latched word
  // ---------------------------------------------------------------------------
  always_comb begin
    if (count_q == '0) begin
      eff_count = CNW'(1);
    end else if (32'(count_q) > MAX_DRIVES) begin
      eff_count = CNW'(MAX_DRIVES);
    end else begin
      eff_count = count_q;
    end
  end

  // round up to whole blocks
  assign round_sum = {1'b0, bytes_q} + NW'(hsc_pkg::BLOCK_BYTES - 1);
  assign need      = {round_sum[NW-1:BS], BS'(0)};

  // an entry never written since reset or reload reads as full
  assign credit  = vld_q[addr_q] ? ram_rdata : cap_q;
  assign fits    = {1'b0, credit} >= need;
  assign ret_sum = {2'b00, credit} + {1'b0, need};
  assign idx_ok  = 32'(drive_index_i) < MAX_DRIVES;

  assign in_stall_o = (state_q != hsc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (state_q)
      hsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == hsc_pkg::CMD_KEY) begin
            mul_start = 1'b1;
            state_d   = hsc_pkg::ST_MUL;
          end else if (idx_ok) begin
            state_d = hsc_pkg::ST_RD;
          end
        end
      end
      hsc_pkg::ST_MUL: begin
        if (mul_st.done) begin
          if (last_q) begin
            mod_start = 1'b1;
            state_d   = hsc_pkg::ST_MOD;
          end else begin
            state_d = hsc_pkg::ST_IDLE;
          end
        end
      end
      hsc_pkg::ST_MOD: begin
        if (mod_st.done) begin
          state_d = data_q ? hsc_pkg::ST_RD : hsc_pkg::ST_OUT;
        end
      end
      hsc_pkg::ST_RD: begin
        state_d = hsc_pkg::ST_UPD;
      end
      hsc_pkg::ST_UPD: begin
        if (cmd_q == hsc_pkg::CMD_RETURN) begin
          ram_we    = 1'b1;
          ram_wdata = (ret_sum > {2'b00, cap_q}) ? cap_q : ret_sum[CRW-1:0];
          state_d   = hsc_pkg::ST_IDLE;
        end else begin
          ram_we    = fits;
          ram_wdata = credit - need[CRW-1:0];
          state_d   = hsc_pkg::ST_OUT;
        end
      end
      hsc_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = hsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hsc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers: config, hash, valid bits, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= hsc_pkg::COUNT_RESET;
      cap_q       <= hsc_pkg::CAP_RESET;
      hash_q      <= hsc_pkg::FNV_BASIS;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // advance the hash, restart it after the last byte
      if (state_q == hsc_pkg::ST_MUL && mul_st.done) begin
        hash_q <= last_q ? hsc_pkg::FNV_BASIS : mul_product;
      end
      // mark a credit entry as written; a capacity write clears every mark
      if (cfg_we && paddr[2] == hsc_pkg::REG_DRIVE_CAPACITY) begin
        vld_q <= '0;
      end else if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      // load a new output word when done, else drop the one taken
      if (state_q == hsc_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // register writes
      if (cfg_we) begin
        unique case (paddr[2])
          hsc_pkg::REG_DRIVE_COUNT: begin
            count_q <= pwdata[CNW-1:0];
          end
          hsc_pkg::REG_DRIVE_CAPACITY: begin
            cap_q <= pwdata[CRW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // latch the accepted word
    if (in_acc) begin
      cmd_q   <= cmd_i;
      last_q  <= key_last_i;
      data_q  <= is_data_op_i;
      bytes_q <= request_bytes_i;
      addr_q  <= AW'(drive_index_i);
    end
    // hold each product; after the last byte this is the final hash
    if (state_q == hsc_pkg::ST_MUL && mul_st.done) begin
      res_hash_q <= mul_product;
    end
    // steer to a drive; non-data requests are granted at no charge
    if (state_q == hsc_pkg::ST_MOD && mod_st.done) begin
      res_drive_q  <= mod_rem;
      addr_q       <= AW'(mod_rem);
      res_grant_q  <= 1'b1;
      res_charge_q <= '0;
    end
    // grant or refuse against the drive's credit
    if (state_q == hsc_pkg::ST_UPD && cmd_q == hsc_pkg::CMD_KEY) begin
      res_grant_q  <= fits;
      res_charge_q <= fits ? need[CRW-1:0] : '0;
    end
    // load the output register
    if (state_q == hsc_pkg::ST_OUT && out_free) begin
      out_drive_q  <= res_drive_q[3:0];
      out_grant_q  <= res_grant_q;
      out_charge_q <= res_charge_q;
      out_hash_q   <= res_hash_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = out_drive_q;
  assign granted_o       = out_grant_q;
  assign charged_bytes_o = out_charge_q;
  assign key_hash_o      = out_hash_q;

`ifndef SYNTHESIS
  // the multiplier and the remainder unit never finish together
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_st.done && mod_st.done))
    else $error("multiply and remainder finished in the same cycle");

  // a refused request is never charged
  a_refused_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (charged_bytes_o == '0))
    else $error("refused request carries a charge");

  // charges are whole blocks
  a_charge_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (charged_bytes_o[BS-1:0] == '0))
    else $error("charge is not a whole number of blocks");

  // a stored credit never exceeds the capacity
  a_credit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata <= cap_q))
    else $error("credit written above capacity");
`endif

endmodule

### dv/tb_hashed_drive_steering_with_credits.sv
// ----------------------------------------------------------------------------
// tb_hashed_drive_steering_with_credits
// Self-checking bench for FNV-1a drive steering with byte credits.
// ----------------------------------------------------------------------------
// Key bytes and credit returns are fed through the valid/stall input channel.
// A local copy of the hash, the drive credits and the two registers predicts
// every result word; the output monitor checks each one field by field. A
// short table of directed words runs first, then random key sequences with
// returns and retries under several drive count / capacity settings written
// over APB. The sender runs in bursts, the receiver stalls on its own pattern
// and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_hashed_drive_steering_with_credits;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned PHASE_WORDS  = 46;
  localparam int unsigned N_DRIVES     = hsc_pkg::MAX_DRIVES;
  localparam int unsigned BLOCK_SHIFT  = hsc_pkg::BLOCK_SHIFT;
  localparam logic        CMD_KEY      = hsc_pkg::CMD_KEY;
  localparam logic        CMD_RETURN   = hsc_pkg::CMD_RETURN;
  localparam logic [63:0] FNV_PRIME_64 = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] HASH_OF_A    = 64'hAF63_DC4C_8601_EC8C;
  localparam logic [2:0]  ADDR_COUNT   = {hsc_pkg::REG_DRIVE_COUNT, 2'b00};
  localparam logic [2:0]  ADDR_CAP     = {hsc_pkg::REG_DRIVE_CAPACITY, 2'b00};

  typedef struct packed {
    logic        cmd;
    logic [7:0]  key_byte;
    logic        key_last;
    logic        is_data_op;
    logic [20:0] request_bytes;
    logic [3:0]  drive_index;
  } word_t;

  typedef struct packed {
    logic [3:0]  drive;
    logic        granted;
    logic [20:0] charged;
    logic [63:0] key_hash;
  } steer_res_t;

  typedef struct packed {
    word_t      w;
    logic       typed;
    steer_res_t want;
  } dir_row_t;

  typedef struct packed {
    logic [3:0]  drive;
    logic [20:0] bytes;
  } loan_t;

  typedef struct packed {
    logic [31:0] count_word;
    logic [31:0] cap_word;
  } setting_t;

  localparam steer_res_t NO_RES = '0;
  localparam int unsigned DIR_N = 22;

  // Directed words under reset settings (4 drives, 262144 bytes each).
  // Key "a" hashes to a known value that lands on drive 0.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // non-data request: always granted, nothing charged
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b0, 21'd0, 4'd0}, 1'b1, '{4'd0, 1'b1, 21'd0, HASH_OF_A}},
    // rounded size beyond the credit width: refused, hash restarts
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'h1FFFFF, 4'd0}, 1'b1,
      '{4'd0, 1'b0, 21'd0, HASH_OF_A}},
    // larger than the capacity: refused
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd1048576, 4'd0}, 1'b1,
      '{4'd0, 1'b0, 21'd0, HASH_OF_A}},
    // zero bytes: granted, nothing charged
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd0, 4'd0}, 1'b1, '{4'd0, 1'b1, 21'd0, HASH_OF_A}},
    // one byte rounds up to a block
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd1, 4'd0}, 1'b1, '{4'd0, 1'b1, 21'd4096, HASH_OF_A}},
    // drain the rest of drive 0
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd258048, 4'd0}, 1'b1,
      '{4'd0, 1'b1, 21'd258048, HASH_OF_A}},
    // empty drive: refused
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd1, 4'd0}, 1'b1, '{4'd0, 1'b0, 21'd0, HASH_OF_A}},
    '{'{CMD_RETURN, 8'h00, 1'b0, 1'b0, 21'd1, 4'd0}, 1'b0, NO_RES},
    // retry after a return
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd4096, 4'd0}, 1'b1,
      '{4'd0, 1'b1, 21'd4096, HASH_OF_A}},
    // oversized return saturates at capacity
    '{'{CMD_RETURN, 8'hFF, 1'b1, 1'b1, 21'h1FFFFF, 4'd0}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h61, 1'b1, 1'b1, 21'd262144, 4'd0}, 1'b1,
      '{4'd0, 1'b1, 21'd262144, HASH_OF_A}},
    '{'{CMD_RETURN, 8'h00, 1'b0, 1'b0, 21'd262144, 4'd0}, 1'b0, NO_RES},
    '{'{CMD_RETURN, 8'hA5, 1'b0, 1'b1, 21'd4097, 4'd15}, 1'b0, NO_RES},
    // multi-byte key with byte extremes
    '{'{CMD_KEY, 8'h00, 1'b0, 1'b1, 21'h1FFFFF, 4'd15}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'hFF, 1'b0, 1'b0, 21'd0, 4'd0}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h80, 1'b0, 1'b1, 21'h0AAAAA, 4'd10}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h7F, 1'b1, 1'b1, 21'd4095, 4'd5}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'hFF, 1'b1, 1'b0, 21'h1FFFFF, 4'd15}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h00, 1'b0, 1'b0, 21'h155555, 4'd5}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h00, 1'b1, 1'b1, 21'd8193, 4'd0}, 1'b0, NO_RES},
    '{'{CMD_RETURN, 8'h3C, 1'b1, 1'b0, 21'd0, 4'd7}, 1'b0, NO_RES},
    '{'{CMD_KEY, 8'h5A, 1'b1, 1'b1, 21'h0FFFFF, 4'd3}, 1'b0, NO_RES}
  };

  // Register settings per phase; upper data bits set on some to check masking
  localparam int unsigned N_PHASES = 8;
  localparam setting_t SETTINGS [N_PHASES] = '{
    '{32'd4,          32'd262144},
    '{32'hFFFF_FFE1,  32'd0},
    '{32'd16,         32'hFFFF_FFFF},
    '{32'd0,          32'd8192},
    '{32'd31,         32'd1048576},
    '{32'd17,         32'd65536},
    '{32'd7,          32'd300000},
    '{32'd3,          32'd262144}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [7:0]  key_byte_i;
  logic        key_last_i;
  logic        is_data_op_i;
  logic [20:0] request_bytes_i;
  logic [3:0]  drive_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  drive_o;
  logic        granted_o;
  logic [20:0] charged_bytes_o;
  logic [63:0] key_hash_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the block's state
  logic [4:0]  count_reg;
  logic [20:0] cap_reg;
  logic [63:0] hash_acc;
  logic [20:0] drive_credit [N_DRIVES];

  steer_res_t  pending_results [$];
  loan_t       open_loans [$];
  logic [7:0]  retry_key [$];
  logic [20:0] retry_bytes;
  bit          retry_pending;
  bit          hold_req;
  int          burst_left;
  int          words_sent;
  int          err_count;
  int          n_results;
  int          n_granted;
  int          n_refused;
  int          n_returns;

  hashed_drive_steering_with_credits dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .key_byte_i      (key_byte_i),
    .key_last_i      (key_last_i),
    .is_data_op_i    (is_data_op_i),
    .request_bytes_i (request_bytes_i),
    .drive_index_i   (drive_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o),
    .granted_o       (granted_o),
    .charged_bytes_o (charged_bytes_o),
    .key_hash_o      (key_hash_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Round a byte count up to whole blocks; one bit wider than a credit
  function automatic logic [21:0] round_to_block(input logic [20:0] bytes);
    logic [21:0] sum;
    sum = {1'b0, bytes} + 22'((1 << BLOCK_SHIFT) - 1);
    return {sum[21:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};
  endfunction

  function automatic void load_credits();
    for (int i = 0; i < N_DRIVES; i++) drive_credit[i] = cap_reg;
  endfunction

  // Advance the local state by one accepted word; flag a result if one is due
  function automatic void steer_request(input word_t w, output bit has_res,
                                        output steer_res_t res);
    logic [22:0] sum;
    logic [21:0] need;
    logic [4:0]  eff;
    logic [63:0] h;
    has_res = 1'b0;
    res = NO_RES;
    need = round_to_block(w.request_bytes);
    if (w.cmd == CMD_RETURN) begin
      sum = {2'b00, drive_credit[w.drive_index]} + {1'b0, need};
      if (sum > {2'b00, cap_reg}) sum = {2'b00, cap_reg};
      drive_credit[w.drive_index] = sum[20:0];
      return;
    end
    h = (hash_acc ^ {56'd0, w.key_byte}) * FNV_PRIME_64;
    hash_acc = h;
    if (!w.key_last) return;
    hash_acc = hsc_pkg::FNV_BASIS;
    if (count_reg == 5'd0) eff = 5'd1;
    else if (count_reg > 5'(N_DRIVES)) eff = 5'(N_DRIVES);
    else eff = count_reg;
    has_res = 1'b1;
    res.key_hash = h;
    res.drive = 4'(h % {59'd0, eff});
    res.granted = 1'b1;
    if (w.is_data_op) begin
      if ({1'b0, drive_credit[res.drive]} >= need) begin
        drive_credit[res.drive] = drive_credit[res.drive] - need[20:0];
        res.charged = need[20:0];
      end else begin
        res.granted = 1'b0;
      end
    end
  endfunction

  // Present one word in bursts with random gaps; predict once it is taken
  task automatic send_word(input word_t w, input bit typed, input steer_res_t typed_res,
                           output bit has_res, output steer_res_t res);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    cmd_i           <= w.cmd;
    key_byte_i      <= w.key_byte;
    key_last_i      <= w.key_last;
    is_data_op_i    <= w.is_data_op;
    request_bytes_i <= w.request_bytes;
    drive_index_i   <= w.drive_index;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    steer_request(w, has_res, res);
    if (has_res) pending_results.insert(pending_results.size(), typed ? typed_res : res);
    if (w.cmd == CMD_RETURN) n_returns++;
    words_sent++;
  endtask

  // Hold the input until every expected word is out and the block settles
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_read(ADDR_COUNT, rd);
    if (rd !== {27'd0, count_reg})
      report_mismatch("drive_count readback", 64'(rd), 64'(count_reg));
    apb_read(ADDR_CAP, rd);
    if (rd !== {11'd0, cap_reg})
      report_mismatch("drive_capacity readback", 64'(rd), 64'(cap_reg));
  endtask

  // Pick a payload size around the current capacity, with full-range outliers
  function automatic logic [20:0] pick_bytes();
    case ($urandom_range(0, 9))
      6:       return 21'($urandom_range(0, 4) << BLOCK_SHIFT);
      7:       return 21'($urandom);
      8:       return cap_reg;
      9:       return cap_reg + 21'd1;
      default: return 21'($urandom_range(0, cap_reg / 2));
    endcase
  endfunction

  // Give credit back, mostly for an earlier grant
  task automatic send_return();
    word_t      w;
    loan_t      l;
    bit         has_res;
    steer_res_t res;
    w.cmd        = CMD_RETURN;
    w.key_byte   = 8'($urandom);
    w.key_last   = 1'($urandom);
    w.is_data_op = 1'($urandom);
    if (open_loans.size() != 0 && $urandom_range(0, 3) != 0) begin
      l = open_loans.pop_front();
      w.drive_index   = l.drive;
      w.request_bytes = l.bytes;
    end else begin
      w.drive_index   = 4'($urandom);
      w.request_bytes = pick_bytes();
    end
    send_word(w, 1'b0, NO_RES, has_res, res);
  endtask

  // Send one key, either fresh or a retry of a refused one
  task automatic send_request();
    word_t      w;
    bit         has_res;
    steer_res_t res;
    loan_t      l;
    logic [7:0] key [$];
    logic [20:0] bytes;
    bit         data_op;
    int         len;
    if (retry_pending) begin
      key = retry_key;
      bytes = retry_bytes;
      data_op = 1'b1;
      retry_pending = 1'b0;
    end else begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      for (int i = 0; i < len; i++) key.insert(key.size(), 8'($urandom));
      bytes = pick_bytes();
      data_op = ($urandom_range(0, 4) != 0);
    end
    foreach (key[i]) begin
      w.cmd         = CMD_KEY;
      w.key_byte    = key[i];
      w.key_last    = (i == key.size() - 1);
      w.drive_index = 4'($urandom);
      if (w.key_last) begin
        w.is_data_op    = data_op;
        w.request_bytes = bytes;
      end else begin
        w.is_data_op    = 1'($urandom);
        w.request_bytes = 21'($urandom);
      end
      send_word(w, 1'b0, NO_RES, has_res, res);
    end
    // Track grants for later returns; retry some refusals
    if (res.granted && res.charged != 21'd0) begin
      l.drive = res.drive;
      l.bytes = res.charged;
      open_loans.insert(open_loans.size(), l);
    end
    if (!res.granted && $urandom_range(0, 1) == 1) begin
      retry_pending = 1'b1;
      retry_key = key;
      retry_bytes = bytes;
    end
  endtask

  task automatic run_random(input int n_words);
    int start;
    bit paused;
    start = words_sent;
    paused = 1'b0;
    while (words_sent - start < n_words) begin
      if (!paused && words_sent - start >= n_words / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ((retry_pending && open_loans.size() != 0) || $urandom_range(0, 4) == 0)
        send_return();
      else
        send_request();
    end
  endtask

  // Receiver: stall on a changing pattern; serve long hold-off requests
  initial begin
    int mode;
    int span;
    int phase;
    out_stall_i <= 1'b0;
    span = 0;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (span <= 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
      end
      span--;
      phase = (phase + 1) % 3;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        2:       out_stall_i <= (phase != 0);
        default: out_stall_i <= 1'($urandom);
      endcase
    end
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    steer_res_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, key_hash", key_hash_o, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (want.granted) n_granted++;
        else n_refused++;
        if (drive_o !== want.drive)
          report_mismatch("drive", 64'(drive_o), 64'(want.drive));
        if (granted_o !== want.granted)
          report_mismatch("granted", 64'(granted_o), 64'(want.granted));
        if (charged_bytes_o !== want.charged)
          report_mismatch("charged_bytes", 64'(charged_bytes_o), 64'(want.charged));
        if (key_hash_o !== want.key_hash)
          report_mismatch("key_hash", key_hash_o, want.key_hash);
      end
    end
  end

  // Stimulus
  initial begin
    bit         has_res;
    steer_res_t res;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cmd_i           <= CMD_KEY;
    key_byte_i      <= 8'd0;
    key_last_i      <= 1'b0;
    is_data_op_i    <= 1'b0;
    request_bytes_i <= 21'd0;
    drive_index_i   <= 4'd0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= 3'd0;
    pwdata          <= 32'd0;
    count_reg     = hsc_pkg::COUNT_RESET;
    cap_reg       = hsc_pkg::CAP_RESET;
    hash_acc      = hsc_pkg::FNV_BASIS;
    load_credits();
    retry_pending = 1'b0;
    hold_req      = 1'b0;
    burst_left    = 0;
    words_sent    = 0;
    err_count     = 0;
    n_results     = 0;
    n_granted     = 0;
    n_refused     = 0;
    n_returns     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYC) @(posedge clk_i);

    for (int p = 0; p < N_PHASES; p++) begin
      // Registers change only with the block idle
      if (p != 0) begin
        drain_results();
        apb_write(ADDR_COUNT, SETTINGS[p].count_word);
        count_reg = SETTINGS[p].count_word[4:0];
        apb_write(ADDR_CAP, SETTINGS[p].cap_word);
        cap_reg = SETTINGS[p].cap_word[20:0];
        load_credits();
        open_loans.delete();
        retry_pending = 1'b0;
      end
      check_registers();
      if (p == 0) begin
        for (int i = 0; i < DIR_N; i++)
          send_word(DIR_ROWS[i].w, DIR_ROWS[i].typed, DIR_ROWS[i].want, has_res, res);
      end
      // Back the block up behind a stalled receiver once
      if (p == 2) hold_req = 1'b1;
      run_random(PHASE_WORDS);
    end

    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("results left over", 64'(pending_results.size()), 64'd0);
    $display("Ran %0d register settings and %0d input words, %0d of them credit returns.",
             N_PHASES, words_sent, n_returns);
    $display("Checked %0d result words: %0d granted, %0d refused; %0d mismatches.",
             n_results, n_granted, n_refused, err_count);
    if (err_count == 0) begin
      $display("tb_hashed_drive_steering_with_credits OK");
    end else begin
      $display("tb_hashed_drive_steering_with_credits NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("[%0t] timeout with %0d results outstanding", $time, pending_results.size());
    $display("tb_hashed_drive_steering_with_credits NOT OK");
    $finish;
  end

endmodule
